>>> rtl/ife_pkg.sv
// Shared constants, types and the character decoder of the infix four-operator evaluator.
package ife_pkg;

  // Datapath word width and the width of the divider step counter.
  localparam int ValueW = 32;
  localparam int CntW   = $clog2(ValueW);

  // Character codes the block reacts to.
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChSpace = 8'h20;

  // Class of one input character.
  typedef enum logic [2:0] {
    CLS_SKIP  = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_MUL   = 3'd2,
    CLS_DIV   = 3'd3,
    CLS_ADD   = 3'd4,
    CLS_SUB   = 3'd5,
    CLS_EQ    = 3'd6
  } cls_t;

  // Pending multiplicative operator; the unused code acts as none.
  typedef enum logic [1:0] {
    MOP_NONE = 2'd0,
    MOP_MUL  = 2'd1,
    MOP_DIV  = 2'd2
  } mulop_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       digit;
    logic [3:0] digit_val;
    logic       fold;
    logic       div_take;
    logic       set_mul;
    logic       mul_is_div;
    logic       fold_term;
    logic       set_add;
    logic       add_is_sub;
    logic       emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_go;
    logic div_done;
    logic out_busy;
  } sts_t;

  // Sort a character into its class; spaces and unknown bytes are skipped.
  function automatic cls_t char_class(input logic [7:0] c);
    cls_t k;
    k = CLS_SKIP;
    if (c >= ChZero && c <= ChNine) begin
      k = CLS_DIGIT;
    end else if (c == ChStar) begin
      k = CLS_MUL;
    end else if (c == ChSlash) begin
      k = CLS_DIV;
    end else if (c == ChPlus) begin
      k = CLS_ADD;
    end else if (c == ChMinus) begin
      k = CLS_SUB;
    end else if (c == ChEqual) begin
      k = CLS_EQ;
    end else if (c == ChSpace) begin
      k = CLS_SKIP;
    end
    return k;
  endfunction

endpackage

>>> rtl/ife_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module ife_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ife_pkg::ValueW-1:0] dividend,
  input  logic [ife_pkg::ValueW-1:0] divisor,
  output logic                      done,
  output logic [ife_pkg::ValueW-1:0] quotient
);
  import ife_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CntW-1:0]   cnt_r;
  logic              neg_r;
  logic [ValueW-1:0] quo_r;
  logic [ValueW-1:0] rem_r;
  logic [ValueW-1:0] den_r;
  logic [ValueW-1:0] a_mag;
  logic [ValueW-1:0] b_mag;
  logic [ValueW:0]   rem_sh;
  logic [ValueW:0]   trial;
  logic              q_bit;

  // Magnitudes of the operands at start.
  assign a_mag = dividend[ValueW-1] ? (~dividend + 1'b1) : dividend;
  assign b_mag = divisor[ValueW-1]  ? (~divisor + 1'b1)  : divisor;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_r, quo_r[ValueW-1]};
  assign trial  = rem_sh - {1'b0, den_r};
  assign q_bit  = ~trial[ValueW];

  // Control: busy for one pass over all quotient bits, then a done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(ValueW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Working registers of the division.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[ValueW-1] ^ divisor[ValueW-1];
      quo_r <= a_mag;
      rem_r <= '0;
      den_r <= b_mag;
    end else if (busy_r) begin
      rem_r <= q_bit ? trial[ValueW-1:0] : rem_sh[ValueW-1:0];
      quo_r <= {quo_r[ValueW-2:0], q_bit};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

>>> rtl/ife_dpath.sv
// Datapath: accumulators, pending operators, multiplier, divider and result register.
module ife_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ife_pkg::cmd_t                    cmd,
  output ife_pkg::sts_t                    sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic signed [ife_pkg::ValueW-1:0] out_tdata,
  output logic [0:0]                       out_tuser
);
  import ife_pkg::*;

  logic [ValueW-1:0]   sum_r, sum_nxt;
  logic [ValueW-1:0]   term_r, term_nxt;
  logic [ValueW-1:0]   operand_r, operand_nxt;
  logic                add_r, add_nxt;
  mulop_t              mul_op_r, mul_op_nxt;
  logic                dz_r, dz_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ValueW-1:0]   out_value_r;
  logic                out_err_r;
  logic [ValueW-1:0]   prod_full;
  logic                div_start;
  logic                div_done;
  logic [ValueW-1:0]   div_q;

  // Low word of the product of the term and the finished operand.
  assign prod_full = term_r * operand_r;

  // A division starts when the operand is folded under a pending nonzero divide.
  assign div_start = cmd.fold && sts.div_go;

  ife_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (term_r),
    .divisor  (operand_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state of the evaluation registers.
  always_comb begin
    sum_nxt     = sum_r;
    term_nxt    = term_r;
    operand_nxt = operand_r;
    add_nxt     = add_r;
    mul_op_nxt  = mul_op_r;
    dz_nxt      = dz_r;
    if (cmd.digit) begin
      operand_nxt = (operand_r << 3) + (operand_r << 1) + ValueW'(cmd.digit_val);
    end
    if (cmd.fold) begin
      operand_nxt = '0;
      case (mul_op_r)
        MOP_MUL: term_nxt = prod_full;
        MOP_DIV: begin
          if (operand_r == '0) begin
            dz_nxt   = 1'b1;
            term_nxt = '0;
          end
        end
        default: term_nxt = operand_r;
      endcase
    end
    if (cmd.div_take) begin
      term_nxt = div_q;
    end
    if (cmd.set_mul) begin
      mul_op_nxt = cmd.mul_is_div ? MOP_DIV : MOP_MUL;
    end
    if (cmd.fold_term) begin
      sum_nxt    = add_r ? (sum_r - term_r) : (sum_r + term_r);
      term_nxt   = '0;
      mul_op_nxt = MOP_NONE;
    end
    if (cmd.set_add) begin
      add_nxt = cmd.add_is_sub;
    end
    if (cmd.emit) begin
      sum_nxt     = '0;
      term_nxt    = '0;
      operand_nxt = '0;
      add_nxt     = 1'b0;
      mul_op_nxt  = MOP_NONE;
      dz_nxt      = 1'b0;
    end
  end

  // Output beat handshake: load on emit, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      term_r      <= '0;
      operand_r   <= '0;
      add_r       <= 1'b0;
      mul_op_r    <= MOP_NONE;
      dz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      term_r      <= term_nxt;
      operand_r   <= operand_nxt;
      add_r       <= add_nxt;
      mul_op_r    <= mul_op_nxt;
      dz_r        <= dz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; a division by zero forces the value to zero.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= dz_r ? '0 : sum_r;
      out_err_r   <= dz_r;
    end
  end

  assign sts.div_go   = (mul_op_r == MOP_DIV) && (operand_r != '0);
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_err_r;

endmodule

>>> rtl/ife_ctrl.sv
// Controller: sequences the folding of operands and terms for each operator beat.
module ife_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  ife_pkg::sts_t sts,
  output ife_pkg::cmd_t cmd
);
  import ife_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FOLD = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_TERM = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  cls_t   kind_r, kind_nxt;
  cls_t   in_cls;
  logic   accept;
  logic   kind_mul;

  assign in_cls    = char_class(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign kind_mul  = (kind_r == CLS_MUL) || (kind_r == CLS_DIV);

  // State transitions and commands.
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd            = '0;
    cmd.digit_val  = in_tdata[3:0];
    cmd.mul_is_div = (kind_r == CLS_DIV);
    cmd.add_is_sub = (kind_r == CLS_SUB);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cls == CLS_DIGIT) begin
            cmd.digit = 1'b1;
          end else if (in_cls != CLS_SKIP) begin
            kind_nxt  = in_cls;
            state_nxt = ST_FOLD;
          end
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (sts.div_go) begin
          state_nxt = ST_DIV;
        end else if (kind_mul) begin
          cmd.set_mul = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_TERM;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          if (kind_mul) begin
            cmd.set_mul = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            state_nxt = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        cmd.fold_term = 1'b1;
        if (kind_r == CLS_EQ) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.set_add = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= CLS_SKIP;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

>>> rtl/infix_four_op_evaluator.sv
// Top level of the infix four-operator evaluator: controller plus datapath.
// The block reads an arithmetic expression one ASCII character per input beat: decimal
// digits build the operand, '*' and '/' bind tighter than '+' and '-', all left to
// right, with 32-bit wrapping arithmetic and division truncating toward zero; spaces
// and unknown bytes are ignored. Each '=' yields one output beat carrying the value in
// out_tdata and a division-by-zero flag in out_tuser (value then 0), and clears the
// evaluation state. One item is processed at a time, no new character being taken
// meanwhile: '*' or '/' folds the operand into the term, '+' or '-' also folds the term
// into the sum, and '=' then waits for the output register to empty. Folding an operand
// under a pending nonzero '/' waits on the divider, which makes one quotient bit per cycle.
module infix_four_op_evaluator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] char_code
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic signed [ife_pkg::ValueW-1:0] out_tdata,  // [31:0] value
  output logic [0:0]                       out_tuser   // [0] error
);
  import ife_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ife_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  ife_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/ife_checker.sv
// Port-level checks of the infix four-operator evaluator and their binding.
module ife_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [7:0]                       in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic signed [ife_pkg::ValueW-1:0] out_tdata,
  input logic [0:0]                       out_tuser
);
  import ife_pkg::*;

  // No result beat is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat shown after reset");

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A division by zero always reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error beat with nonzero value");

  // Only an '=' beat can produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata != ChEqual) && !out_tvalid |=> !out_tvalid)
    else $error("result beat without an equals character");

endmodule

bind infix_four_op_evaluator ife_checker u_ife_checker (.*);
